// ===== hdl/adsr_pkg.sv =====
package adsr_pkg;

  localparam int ADDR_W = 5;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_NEW_ADSR_MODE = 3'd0;
  localparam reg_idx_t REG_SWAP_PAN      = 3'd1;
  localparam reg_idx_t REG_ATTACK_RATE   = 3'd2;
  localparam reg_idx_t REG_DECAY_RATE    = 3'd3;
  localparam reg_idx_t REG_SUSTAIN_LEVEL = 3'd4;
  localparam reg_idx_t REG_RELEASE_RATE  = 3'd5;
  localparam reg_idx_t REG_FINE_PATTERNS = 3'd6;

  localparam logic [1:0] KIND_KEY_ON  = 2'd1;
  localparam logic [1:0] KIND_KEY_OFF = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [7:0] PAN_CENTER = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_ENV,
    C_MUL,
    C_PAN,
    C_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  volume;
    logic [7:0]  pan;
    logic [15:0] fadeout;
    logic [7:0]  gate_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] volume_word;
    logic        voice_ended;
  } out_item_t;

  typedef struct packed {
    logic        new_adsr_mode;
    logic        swap_pan;
    logic [7:0]  attack_rate;
    logic [7:0]  decay_rate;
    logic [7:0]  sustain_level;
    logic [7:0]  release_rate;
    logic [23:0] fine_patterns;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic env_step;
    logic mul_step;
    logic pan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic ended;
  } stat_t;

endpackage

// ===== hdl/adsr_regs.sv =====
module adsr_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready,
  output adsr_pkg::cfg_t               cfg
);
  import adsr_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_NEW_ADSR_MODE: cfg_r.new_adsr_mode <= cfg_pwdata[0];
        REG_SWAP_PAN:      cfg_r.swap_pan      <= cfg_pwdata[0];
        REG_ATTACK_RATE:   cfg_r.attack_rate   <= cfg_pwdata[7:0];
        REG_DECAY_RATE:    cfg_r.decay_rate    <= cfg_pwdata[7:0];
        REG_SUSTAIN_LEVEL: cfg_r.sustain_level <= cfg_pwdata[7:0];
        REG_RELEASE_RATE:  cfg_r.release_rate  <= cfg_pwdata[7:0];
        REG_FINE_PATTERNS: cfg_r.fine_patterns <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NEW_ADSR_MODE: cfg_prdata = {31'd0, cfg_r.new_adsr_mode};
      REG_SWAP_PAN:      cfg_prdata = {31'd0, cfg_r.swap_pan};
      REG_ATTACK_RATE:   cfg_prdata = {24'd0, cfg_r.attack_rate};
      REG_DECAY_RATE:    cfg_prdata = {24'd0, cfg_r.decay_rate};
      REG_SUSTAIN_LEVEL: cfg_prdata = {24'd0, cfg_r.sustain_level};
      REG_RELEASE_RATE:  cfg_prdata = {24'd0, cfg_r.release_rate};
      REG_FINE_PATTERNS: cfg_prdata = {8'd0, cfg_r.fine_patterns};
      default:           cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/adsr_ctrl.sv =====
module adsr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  adsr_pkg::stat_t stat,
  output adsr_pkg::cmd_t  cmd
);
  import adsr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != C_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (in_valid) state_nxt = C_ENV;
      C_ENV: begin
        if (!stat.has_result) state_nxt = C_IDLE;
        else if (stat.ended)  state_nxt = C_OUT;
        else                  state_nxt = C_MUL;
      end
      C_MUL: state_nxt = C_PAN;
      C_PAN: state_nxt = C_OUT;
      C_OUT: if (out_free) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      C_IDLE: cmd.load_in  = in_valid;
      C_ENV:  cmd.env_step = 1'b1;
      C_MUL:  cmd.mul_step = 1'b1;
      C_PAN:  cmd.pan_step = 1'b1;
      C_OUT:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_env: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == C_ENV))
    else $error("accepted transfer did not start envelope step");

  a_out_hold_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_OUT && out_valid_r && out_stall) |=> (state_r == C_OUT))
    else $error("result left OUT while output register was full");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("output load did not raise valid");

endmodule

// ===== hdl/adsr_dp.sv =====
module adsr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  adsr_pkg::cfg_t      cfg,
  input  adsr_pkg::in_item_t  in_data,
  input  adsr_pkg::cmd_t      cmd,
  output adsr_pkg::stat_t     stat,
  output adsr_pkg::out_item_t out_data
);
  import adsr_pkg::*;

  in_item_t  in_r;
  out_item_t out_r;

  logic [7:0] level_r, level_nxt;
  stage_t     stage_r, stage_nxt;
  logic       tog_r, tog_nxt;
  logic [7:0] gate_r, gate_nxt;
  logic [7:0] afine_r, afine_nxt;
  logic [7:0] dfine_r, dfine_nxt;
  logic [7:0] rfine_r, rfine_nxt;
  logic       ended_r;

  logic [15:0] p_r, p_nxt;
  logic [15:0] word_r;

  logic       key_on, active, running, ended;
  logic [7:0] atk, dec, rel;
  logic [8:0] atk_sum, dec_lim;

  logic [8:0]  mul_a;
  logic [7:0]  mul_b;
  logic [16:0] prod;
  logic [6:0]  pan_fac;
  logic [7:0]  pan_neg;
  logic [15:0] left, right;

  // envelope step
  always_comb begin
    key_on    = (in_r.kind == KIND_KEY_ON);
    level_nxt = level_r;
    stage_nxt = stage_r;
    tog_nxt   = tog_r;
    gate_nxt  = gate_r;
    afine_nxt = afine_r;
    dfine_nxt = dfine_r;
    rfine_nxt = rfine_r;
    ended     = 1'b0;

    if (key_on) begin
      stage_nxt = ST_ATTACK;
      tog_nxt   = 1'b0;
      gate_nxt  = 8'd0;
      afine_nxt = cfg.fine_patterns[23:16];
      dfine_nxt = cfg.fine_patterns[15:8];
      rfine_nxt = cfg.fine_patterns[7:0];
    end else if (in_r.kind == KIND_KEY_OFF) begin
      gate_nxt = 8'd1;
    end

    // gate countdown forces release when it expires
    if (gate_nxt != 8'd0) begin
      gate_nxt = gate_nxt - 8'd1;
      if (gate_nxt == 8'd0) begin
        stage_nxt = ST_RELEASE;
        tog_nxt   = 1'b0;
      end
    end

    running = (stage_nxt != ST_IDLE);
    atk     = cfg.attack_rate  + {7'd0, afine_nxt[7]};
    dec     = cfg.decay_rate   + {7'd0, dfine_nxt[7]};
    rel     = cfg.release_rate + {7'd0, rfine_nxt[7]};
    atk_sum = {1'b0, level_r} + {1'b0, atk};
    dec_lim = {1'b0, cfg.sustain_level} + {1'b0, dec};

    case (stage_nxt)
      ST_ATTACK: begin
        if (atk_sum[8]) begin
          level_nxt = 8'hff;
          stage_nxt = ST_DECAY;
        end else begin
          level_nxt = atk_sum[7:0];
        end
        if (cfg.new_adsr_mode) afine_nxt = {afine_nxt[6:0], afine_nxt[7]};
      end
      ST_DECAY: begin
        if ({1'b0, level_r} <= dec_lim) begin
          level_nxt = cfg.sustain_level;
          stage_nxt = ST_SUSTAIN;
        end else begin
          level_nxt = level_r - dec;
        end
        if (cfg.new_adsr_mode) dfine_nxt = {dfine_nxt[6:0], dfine_nxt[7]};
      end
      ST_RELEASE: begin
        tog_nxt = ~tog_nxt;
        if (tog_nxt || cfg.new_adsr_mode) begin
          if (level_r < rel) ended = 1'b1;
          else               level_nxt = level_r - rel;
        end
        if (!ended && cfg.new_adsr_mode) rfine_nxt = {rfine_nxt[6:0], rfine_nxt[7]};
      end
      default: ;
    endcase

    // release underflow ends the voice
    if (ended) begin
      level_nxt = 8'd0;
      stage_nxt = ST_IDLE;
      tog_nxt   = 1'b0;
      gate_nxt  = 8'd0;
    end

    if (key_on) gate_nxt = in_r.gate_time;

    active = key_on || (in_r.kind != KIND_UNUSED && stage_r != ST_IDLE);
  end

  assign stat.has_result = active && running;
  assign stat.ended      = active && ended;

  // one multiplier shared by the volume and pan products
  assign pan_neg = 8'd0 - in_r.pan;
  assign pan_fac = in_r.pan[7] ? pan_neg[6:0] : in_r.pan[6:0];
  assign mul_a   = cmd.pan_step ? {p_r[15:8], 1'b0} : {1'b0, in_r.volume};
  assign mul_b   = cmd.pan_step ? {1'b0, pan_fac} : level_r;
  assign prod    = {8'd0, mul_a} * {9'd0, mul_b};

  assign p_nxt = (prod[15:0] < in_r.fadeout) ? 16'd0 : (prod[15:0] - in_r.fadeout);

  always_comb begin
    left  = {p_r[15:8], 8'd0};
    right = {p_r[15:8], 8'd0};
    if (in_r.pan < PAN_CENTER)      right = prod[15:0];
    else if (in_r.pan > PAN_CENTER) left  = prod[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 8'd0;
      stage_r <= ST_IDLE;
      tog_r   <= 1'b0;
      gate_r  <= 8'd0;
      afine_r <= 8'd0;
      dfine_r <= 8'd0;
      rfine_r <= 8'd0;
      ended_r <= 1'b0;
    end else if (cmd.env_step && active) begin
      level_r <= level_nxt;
      stage_r <= stage_nxt;
      tog_r   <= tog_nxt;
      gate_r  <= gate_nxt;
      afine_r <= afine_nxt;
      dfine_r <= dfine_nxt;
      rfine_r <= rfine_nxt;
      ended_r <= ended;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.mul_step) p_r <= p_nxt;
    if (cmd.pan_step) begin
      word_r <= cfg.swap_pan ? {right[15:8], left[15:8]} : {left[15:8], right[15:8]};
    end
    if (cmd.out_load) begin
      out_r.volume_word <= ended_r ? 16'd0 : word_r;
      out_r.voice_ended <= ended_r;
    end
  end

  assign out_data = out_r;

  a_ended_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (stage_r == ST_IDLE && level_r == 8'd0 && gate_r == 8'd0))
    else $error("ended voice left state behind");

  a_idle_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.env_step && stage_r == ST_IDLE && in_r.kind != KIND_KEY_ON) |=> $stable(level_r))
    else $error("idle voice changed level");

  a_ended_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.ended |-> stat.has_result)
    else $error("underflow without result");

endmodule

// ===== hdl/adsr_envelope_with_pan_volume_top.sv =====
// An item with a result passes through the envelope step, volume product, pan product and
// output load states before it shows on out_valid; a voice-end result skips both products.
// The block takes no new item until the last one is through; the single multiplier is used
// twice per item with a result, and a result that finds the output register still full
// waits out the stall. in_stall is high while an item is busy.
// Reset: synchronous, active-low rst_n clears envelope state, registers and handshakes.
module adsr_envelope_with_pan_volume_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  adsr_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output adsr_pkg::out_item_t          out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import adsr_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  adsr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  adsr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
